// ===== hdl/trz_pkg.sv =====
// ----------------------------------------------------------------------------
// trz_pkg
// Shared types, constants and command structs for the triangle rasterizer.
// ----------------------------------------------------------------------------
package trz_pkg;

  localparam int FB_WIDTH      = 64;
  localparam int FB_HEIGHT     = 64;
  localparam int SUBPIXEL_BITS = 4;
  localparam int XW            = $clog2(FB_WIDTH);
  localparam int YW            = $clog2(FB_HEIGHT);
  localparam int AW            = XW + YW;
  localparam int PIX_COUNT     = FB_WIDTH * FB_HEIGHT;
  localparam int EW            = 36;
  localparam int NW            = 54;
  localparam int DIVN          = 4;

  localparam logic [1:0] REQ_DRAW  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [12:0] COUNT_MAX = 13'd8191;

  typedef struct packed {
    logic [5:0]  pixel_y;
    logic [5:0]  pixel_x;
    logic [47:0] color_c;
    logic [47:0] color_b;
    logic [47:0] color_a;
    logic [47:0] vertex_c;
    logic [47:0] vertex_b;
    logic [47:0] vertex_a;
    logic [1:0]  req_type;
  } req_t;

  typedef struct packed {
    logic [12:0] pixels_written;
    logic [15:0] read_depth;
    logic [47:0] read_color;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_BOX, ST_EDGE, ST_TEST, ST_MUL, ST_DIV,
    ST_DTEST, ST_WRITE, ST_NEXT, ST_CLEAR, ST_READ, ST_READ2, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic box;
    logic edge_calc;
    logic mul;
    logic div_start;
    logic rd_pix;
    logic wr_pix;
    logic next_pix;
    logic clr_step;
    logic rd_req;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic area_zero;
    logic box_empty;
    logic covered;
    logic last_pix;
    logic div_busy;
    logic depth_pass;
    logic clr_last;
  } sts_t;

endpackage

// ===== hdl/triangle_raster_zbuffer_core.sv =====
// ----------------------------------------------------------------------------
// triangle_raster_zbuffer_core
// Edge-function triangle rasterizer with a 64x64 depth and color store.
// ----------------------------------------------------------------------------
// One request at a time. A draw steps through accept, setup, box, clamp,
// first test and hand-off, and each covered box pixel waits for the
// one-bit-per-cycle 54-bit divider that normalizes the barycentric sums.
// A clear writes one entry per cycle. The hand-off waits while a previous
// result item is still stalled. After reset a clearing pass over all 4096
// entries runs before the first item is accepted; it returns no result.
// Each item returns one result item.
module triangle_raster_zbuffer_core import trz_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_data
);

  cmd_t cmd;
  sts_t sts;

  trz_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_type(in_data.req_type), .in_valid(in_valid),
    .in_stall(in_stall), .out_stall(out_stall), .out_valid(out_valid),
    .sts(sts), .cmd(cmd)
  );

  trz_datapath u_dp (
    .clk(clk), .rst(rst), .req(in_data), .cmd(cmd), .sts(sts), .rsp(out_data)
  );

endmodule

// ===== hdl/trz_divider.sv =====
// ----------------------------------------------------------------------------
// trz_divider
// Restoring divider, four unsigned quotients against one shared divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module trz_divider import trz_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [DIVN-1:0][NW-1:0] num,
  input  logic [EW-1:0]           den,
  output logic                    busy,
  output logic [DIVN-1:0][15:0]   quo
);

  logic [DIVN-1:0][NW-1:0] rem;
  logic [DIVN-1:0][NW-1:0] q;
  logic [5:0]              cnt;
  logic [EW-1:0]           dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'(NW);
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv <= den;
      for (int i = 0; i < DIVN; i++) begin
        rem[i] <= '0;
        q[i]   <= num[i];
      end
    end else if (busy) begin
      for (int i = 0; i < DIVN; i++) begin
        logic [NW:0] t;
        t = {rem[i], q[i][NW-1]};
        if (t >= {{(NW+1-EW){1'b0}}, dv}) begin
          rem[i] <= NW'(t - {{(NW+1-EW){1'b0}}, dv});
          q[i]   <= {q[i][NW-2:0], 1'b1};
        end else begin
          rem[i] <= t[NW-1:0];
          q[i]   <= {q[i][NW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DIVN; i++) quo[i] = q[i][15:0];
  end

endmodule

// ===== hdl/trz_datapath.sv =====
// ----------------------------------------------------------------------------
// trz_datapath
// Setup, edge evaluation, interpolation and the depth/color store.
// ----------------------------------------------------------------------------
module trz_datapath import trz_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t rsp
);

  req_t r;
  logic signed [16:0] x0, y0, x1, y1, x2, y2;
  logic signed [EW-1:0] area;
  logic signed [17:0] minx, maxx, miny, maxy;
  logic [XW-1:0] bx0, bx1, cx;
  logic [YW-1:0] by1, cy;
  logic signed [EW-1:0] w0, w1, w2;
  logic [DIVN-1:0][NW-1:0] num;
  logic [DIVN-1:0][15:0] quo;
  logic div_busy;
  logic [15:0] depth_mem [PIX_COUNT];
  logic [47:0] color_mem [PIX_COUNT];
  logic [15:0] depth_rd;
  logic [47:0] color_rd;
  logic [AW-1:0] clr_addr;
  logic [12:0] count;
  logic [AW-1:0] addr;
  logic box_empty;
  logic area_zero;
  rsp_t rsp_next;

  function automatic logic signed [17:0] ffloor(input logic signed [16:0] v);
    return 18'(v >>> SUBPIXEL_BITS);
  endfunction

  function automatic logic signed [16:0] min3(input logic signed [16:0] a, b, c);
    logic signed [16:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [16:0] max3(input logic signed [16:0] a, b, c);
    logic signed [16:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic signed [EW-1:0] edgef(
    input logic signed [17:0] ax, ay, bx, by, px, py);
    return EW'((px - ax) * (by - ay)) - EW'((py - ay) * (bx - ax));
  endfunction

  logic signed [17:0] px, py;
  assign px = 18'($signed({1'b0, cx}) * (2 ** SUBPIXEL_BITS) + 2 ** (SUBPIXEL_BITS - 1));
  assign py = 18'($signed({1'b0, cy}) * (2 ** SUBPIXEL_BITS) + 2 ** (SUBPIXEL_BITS - 1));
  assign addr = {cy, cx};

  always_ff @(posedge clk) begin
    if (cmd.load) r <= req;
    if (cmd.setup) begin
      x0 <= 17'($signed(r.vertex_a[15:0]));  y0 <= 17'($signed(r.vertex_a[31:16]));
      x1 <= 17'($signed(r.vertex_b[15:0]));  y1 <= 17'($signed(r.vertex_b[31:16]));
      x2 <= 17'($signed(r.vertex_c[15:0]));  y2 <= 17'($signed(r.vertex_c[31:16]));
      count <= '0;
    end
    if (cmd.box) begin
      area <= edgef(18'(x0), 18'(y0), 18'(x1), 18'(y1), 18'(x2), 18'(y2));
      minx <= ffloor(min3(x0, x1, x2));
      maxx <= -ffloor(-max3(x0, x1, x2));
      miny <= ffloor(min3(y0, y1, y2));
      maxy <= -ffloor(-max3(y0, y1, y2));
    end
    if (cmd.edge_calc) begin
      w0 <= edgef(18'(x1), 18'(y1), 18'(x2), 18'(y2), px, py);
      w1 <= edgef(18'(x2), 18'(y2), 18'(x0), 18'(y0), px, py);
      w2 <= edgef(18'(x0), 18'(y0), 18'(x1), 18'(y1), px, py);
    end
    if (cmd.mul) begin
      for (int k = 0; k < DIVN; k++) begin
        logic [15:0] a, b, c;
        if (k == 0) begin
          a = r.vertex_a[47:32]; b = r.vertex_b[47:32]; c = r.vertex_c[47:32];
        end else begin
          a = r.color_a[16*(k-1) +: 16];
          b = r.color_b[16*(k-1) +: 16];
          c = r.color_c[16*(k-1) +: 16];
        end
        num[k] <= NW'(w0) * NW'(a) + NW'(w1) * NW'(b) + NW'(w2) * NW'(c);
      end
    end
    if (cmd.wr_pix && count != COUNT_MAX) count <= count + 13'd1;
  end

  // box clamp and pixel walk
  logic signed [17:0] cminx, cmaxx, cminy, cmaxy;
  always_comb begin
    cminx = (minx < 0) ? 18'sd0 : minx;
    cminy = (miny < 0) ? 18'sd0 : miny;
    cmaxx = (maxx > FB_WIDTH - 1) ? 18'(FB_WIDTH - 1) : maxx;
    cmaxy = (maxy > FB_HEIGHT - 1) ? 18'(FB_HEIGHT - 1) : maxy;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) clr_addr <= '0;
    else if (cmd.clr_step) clr_addr <= clr_addr + AW'(1);
  end

  // box registered in the cycle after the box command
  logic box_d;
  always_ff @(posedge clk) begin
    box_d <= cmd.box;
    if (box_d) begin
      bx0 <= cminx[XW-1:0];
      bx1 <= cmaxx[XW-1:0];
      by1 <= cmaxy[YW-1:0];
      cx  <= cminx[XW-1:0];
      cy  <= cminy[YW-1:0];
      box_empty <= (cminx > cmaxx) || (cminy > cmaxy);
      area_zero <= (area == '0);
    end else if (cmd.next_pix) begin
      if (cx == bx1) begin
        cx <= bx0;
        cy <= cy + YW'(1);
      end else begin
        cx <= cx + XW'(1);
      end
    end else if (cmd.rd_req) begin
      cx <= r.pixel_x[XW-1:0];
      cy <= r.pixel_y[YW-1:0];
    end
  end

  trz_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(num), .den(area),
    .busy(div_busy), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      depth_mem[clr_addr] <= 16'hFFFF;
      color_mem[clr_addr] <= '0;
    end else if (cmd.wr_pix) begin
      depth_mem[addr] <= quo[0];
      color_mem[addr] <= {quo[3], quo[2], quo[1]};
    end
    if (cmd.rd_pix) begin
      depth_rd <= depth_mem[addr];
      color_rd <= color_mem[addr];
    end
  end

  always_comb begin
    rsp_next = '0;
    if (r.req_type == REQ_DRAW) rsp_next.pixels_written = count;
    if (r.req_type == REQ_READ && {1'b0, r.pixel_x} < 7'(FB_WIDTH) &&
        {1'b0, r.pixel_y} < 7'(FB_HEIGHT)) begin
      rsp_next.read_color = color_rd;
      rsp_next.read_depth = depth_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) rsp <= rsp_next;
  end

  assign sts.area_zero  = area_zero;
  assign sts.box_empty  = box_empty;
  assign sts.covered    = !w0[EW-1] && !w1[EW-1] && !w2[EW-1];
  assign sts.last_pix   = (cx == bx1) && (cy == by1);
  assign sts.div_busy   = div_busy;
  assign sts.depth_pass = quo[0] < depth_rd;
  assign sts.clr_last   = (clr_addr == AW'(PIX_COUNT - 1));

endmodule

// ===== hdl/trz_ctrl.sv =====
// ----------------------------------------------------------------------------
// trz_ctrl
// Request sequencer: clear sweep, read, and the bounding box walk.
// ----------------------------------------------------------------------------
module trz_ctrl import trz_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] req_type,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       out_stall,
  output logic       out_valid,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state, state_next;
  logic [1:0] rtype;
  logic out_valid_next;
  logic boot_clr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
      boot_clr  <= 1'b1;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (state == ST_CLEAR && sts.clr_last) boot_clr <= 1'b0;
    end
    if (in_valid && !in_stall) rtype <= req_type;
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    out_valid_next = out_valid && out_stall;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        unique case (rtype)
          REQ_DRAW:  begin cmd.setup = 1'b1; state_next = ST_BOX; end
          REQ_READ:  begin cmd.rd_req = 1'b1; state_next = ST_READ; end
          REQ_CLEAR: state_next = ST_CLEAR;
          default:   state_next = ST_DONE;
        endcase
      end
      ST_BOX: begin cmd.box = 1'b1; state_next = ST_EDGE; end
      ST_EDGE: begin
        cmd.setup = 1'b0;
        state_next = ST_TEST;
      end
      ST_TEST: begin
        if (sts.area_zero || sts.box_empty) state_next = ST_DONE;
        else begin
          cmd.edge_calc = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (!sts.covered) begin
          state_next = ST_NEXT;
        end else begin
          cmd.mul = 1'b1;
          cmd.rd_pix = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin cmd.div_start = 1'b1; state_next = ST_DTEST; end
      ST_DTEST: if (!sts.div_busy) state_next = ST_WRITE;
      ST_WRITE: begin
        cmd.wr_pix = sts.depth_pass;
        state_next = ST_NEXT;
      end
      ST_NEXT: begin
        if (sts.last_pix) state_next = ST_DONE;
        else begin
          cmd.next_pix = 1'b1;
          state_next = ST_READ2;
        end
      end
      ST_READ2: begin cmd.edge_calc = 1'b1; state_next = ST_MUL; end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        // the sweep after reset returns no item
        if (sts.clr_last) state_next = boot_clr ? ST_IDLE : ST_DONE;
      end
      ST_READ: begin cmd.rd_pix = 1'b1; state_next = ST_DONE; end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.capture = 1'b1;
          out_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== verif/trz_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trz_checker
// Watches both channels of the rasterizer, keeps its own copy of the depth
// and color store, predicts one result per accepted item and compares the
// results in order.
// ----------------------------------------------------------------------------
module trz_checker import trz_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  req_t in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  rsp_t out_data,
  output int   errors,
  output int   pending
);

  logic [15:0] zmem [0:PIX_COUNT-1];
  logic [47:0] cmem [0:PIX_COUNT-1];
  rsp_t        expq [$];

  assign pending = expq.size();

  task automatic report(input string msg);
    $display("trz_checker: %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void wipe_store();
    for (int i = 0; i < PIX_COUNT; i++) begin
      zmem[i] = 16'hFFFF;
      cmem[i] = '0;
    end
  endfunction

  function automatic longint edge_val(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy);
    return (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
  endfunction

  function automatic logic [12:0] raster_tri(req_t q);
    longint vx [3], vy [3], vz [3];
    longint area, x0, x1, y0, y1, px, py, w0, w1, w2, z, ch;
    logic [47:0] col [3];
    logic [47:0] pk;
    logic [12:0] cnt;
    int idx;
    cnt = '0;
    col[0] = q.color_a; col[1] = q.color_b; col[2] = q.color_c;
    vx[0] = $signed(q.vertex_a[15:0]); vy[0] = $signed(q.vertex_a[31:16]);
    vx[1] = $signed(q.vertex_b[15:0]); vy[1] = $signed(q.vertex_b[31:16]);
    vx[2] = $signed(q.vertex_c[15:0]); vy[2] = $signed(q.vertex_c[31:16]);
    vz[0] = q.vertex_a[47:32]; vz[1] = q.vertex_b[47:32]; vz[2] = q.vertex_c[47:32];
    area = edge_val(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
    if (area == 0) return cnt;
    x0 = vx[0]; x1 = vx[0]; y0 = vy[0]; y1 = vy[0];
    for (int k = 1; k < 3; k++) begin
      if (vx[k] < x0) x0 = vx[k];
      if (vx[k] > x1) x1 = vx[k];
      if (vy[k] < y0) y0 = vy[k];
      if (vy[k] > y1) y1 = vy[k];
    end
    x0 = x0 >>> SUBPIXEL_BITS;
    y0 = y0 >>> SUBPIXEL_BITS;
    x1 = -((-x1) >>> SUBPIXEL_BITS);
    y1 = -((-y1) >>> SUBPIXEL_BITS);
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > FB_WIDTH - 1) x1 = FB_WIDTH - 1;
    if (y1 > FB_HEIGHT - 1) y1 = FB_HEIGHT - 1;
    for (longint y = y0; y <= y1; y++) begin
      for (longint x = x0; x <= x1; x++) begin
        px = x * (1 << SUBPIXEL_BITS) + (1 << (SUBPIXEL_BITS - 1));
        py = y * (1 << SUBPIXEL_BITS) + (1 << (SUBPIXEL_BITS - 1));
        w0 = edge_val(vx[1], vy[1], vx[2], vy[2], px, py);
        w1 = edge_val(vx[2], vy[2], vx[0], vy[0], px, py);
        w2 = edge_val(vx[0], vy[0], vx[1], vy[1], px, py);
        if (w0 < 0 || w1 < 0 || w2 < 0) continue;
        z = (w0 * vz[0] + w1 * vz[1] + w2 * vz[2]) / area;
        idx = int'(y) * FB_WIDTH + int'(x);
        if (z >= longint'(zmem[idx])) continue;
        for (int c = 0; c < 3; c++) begin
          ch = (w0 * longint'(col[0][c*16 +: 16]) + w1 * longint'(col[1][c*16 +: 16])
                + w2 * longint'(col[2][c*16 +: 16])) / area;
          pk[c*16 +: 16] = ch[15:0];
        end
        zmem[idx] = z[15:0];
        cmem[idx] = pk;
        if (cnt != COUNT_MAX) cnt++;
      end
    end
    return cnt;
  endfunction

  function automatic rsp_t predict(req_t q);
    rsp_t r;
    int idx;
    r = '0;
    case (q.req_type)
      REQ_DRAW: r.pixels_written = raster_tri(q);
      REQ_READ: begin
        idx = int'(q.pixel_y) * FB_WIDTH + int'(q.pixel_x);
        r.read_color = cmem[idx];
        r.read_depth = zmem[idx];
      end
      REQ_CLEAR: wipe_store();
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      errors = 0;
      wipe_store();
      expq.delete();
    end else begin
      if (in_valid && !in_stall) expq.insert(expq.size(), predict(in_data));
      if (out_valid && !out_stall) begin
        if (expq.size() == 0) begin
          report("result item with nothing expected");
        end else begin
          e = expq.pop_front();
          if (out_data.read_color !== e.read_color)
            report($sformatf("read_color %h, expected %h", out_data.read_color,
                             e.read_color));
          if (out_data.read_depth !== e.read_depth)
            report($sformatf("read_depth %h, expected %h", out_data.read_depth,
                             e.read_depth));
          if (out_data.pixels_written !== e.pixels_written)
            report($sformatf("pixels_written %0d, expected %0d",
                             out_data.pixels_written, e.pixels_written));
        end
      end
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the triangle rasterizer: directed draws, reads and
// clears, then random phases with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top import trz_pkg::*; ();

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;
  int   errors;
  int   pending;
  int   gap_pct;
  int   stall_pct;

  localparam logic [1:0] REQ_SPARE = 2'd3;

  triangle_raster_zbuffer_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  trz_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #300_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [47:0] vtx(int x, int y, int z);
    logic [15:0] xs, ys, zs;
    xs = 16'(x); ys = 16'(y); zs = 16'(z);
    return {zs, ys, xs};
  endfunction

  function automatic req_t noise_item();
    logic [319:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
    return raw[$bits(req_t)-1:0];
  endfunction

  task automatic send(input req_t r);
    int g;
    in_data  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      g = $urandom_range(1, 6);
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic draw(input logic [47:0] a, b, c, ca, cb, cc);
    req_t r;
    r = noise_item();
    r.req_type = REQ_DRAW;
    r.vertex_a = a; r.vertex_b = b; r.vertex_c = c;
    r.color_a = ca; r.color_b = cb; r.color_c = cc;
    send(r);
  endtask

  task automatic read_pix(input int x, input int y);
    req_t r;
    r = noise_item();
    r.req_type = REQ_READ;
    r.pixel_x = 6'(x); r.pixel_y = 6'(y);
    send(r);
  endtask

  task automatic plain(input logic [1:0] kind);
    req_t r;
    r = noise_item();
    r.req_type = kind;
    send(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int n, input int gp, input int sp);
    int sel, bx, by;
    req_t r;
    gap_pct = gp;
    stall_pct = sp;
    for (int i = 0; i < n; i++) begin
      r = noise_item();
      sel = $urandom_range(99);
      if (sel < 52) begin
        r.req_type = REQ_DRAW;
        if (sel < 42) begin
          bx = $urandom_range(0, 1100) - 40;
          by = $urandom_range(0, 1100) - 40;
        end else begin
          bx = $urandom_range(0, 65535) - 32768;
          by = $urandom_range(0, 65535) - 32768;
        end
        r.vertex_a[31:0] = {16'(by), 16'(bx)};
        r.vertex_b[31:0] = {16'(by + $urandom_range(0, 160) - 80),
                            16'(bx + $urandom_range(0, 160) - 80)};
        if ($urandom_range(15) == 0) r.vertex_c[31:0] = r.vertex_b[31:0];
        else r.vertex_c[31:0] = {16'(by + $urandom_range(0, 160) - 80),
                                 16'(bx + $urandom_range(0, 160) - 80)};
      end else if (sel < 94) begin
        r.req_type = REQ_READ;
      end else if (sel < 96) begin
        r.req_type = REQ_CLEAR;
      end else begin
        r.req_type = REQ_SPARE;
      end
      send(r);
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    gap_pct   = 0;
    stall_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    read_pix(0, 0);
    read_pix(63, 63);
    // small positive triangle, then farthest depth on cleared pixels
    draw(vtx(32, 32, 100), vtx(32, 160, 2000), vtx(160, 32, 40000),
         48'h0000_8000_FFFF, 48'hFFFF_0000_0100, 48'h1234_FFFF_0000);
    draw(vtx(400, 400, 16'hFFFF), vtx(400, 520, 16'hFFFF), vtx(520, 400, 16'hFFFF),
         '1, '1, '1);
    read_pix(3, 3);
    read_pix(2, 2);
    // reversed winding and zero area
    draw(vtx(32, 32, 0), vtx(160, 32, 0), vtx(32, 160, 0), '1, '1, '1);
    draw(vtx(16, 16, 0), vtx(48, 48, 0), vtx(80, 80, 0), '1, '1, '1);
    // box entirely off screen
    draw(vtx(-800, -800, 0), vtx(-800, -700, 0), vtx(-700, -800, 0), '1, '1, '1);
    draw(vtx(2000, 50, 0), vtx(2000, 150, 0), vtx(2100, 50, 0), '1, '1, '1);
    // nearer overlap, then a farther one that must lose
    draw(vtx(0, 0, 50), vtx(0, 200, 50), vtx(200, 0, 50), '0, '0, '1);
    draw(vtx(0, 0, 60000), vtx(0, 200, 60000), vtx(200, 0, 60000), '1, '1, '1);
    read_pix(3, 3);
    read_pix(1, 5);
    plain(REQ_SPARE);
    plain(REQ_CLEAR);
    read_pix(3, 3);
    // extreme coordinates: half of the screen
    draw(vtx(-32768, -32768, 0), vtx(-32768, 32767, 65535), vtx(32767, 32767, 1),
         48'hFFFF_FFFF_FFFF, 48'h0, 48'h8000_0001_7FFF);
    read_pix(0, 63);
    read_pix(63, 0);
    read_pix(31, 32);
    drain();

    random_phase(440, 0, 0);
    random_phase(440, 55, 0);
    drain();
    random_phase(440, 0, 55);
    random_phase(440, 10, 10);
    drain();
    repeat (100) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
